FILE: hw/rtl/keyed_tail_log_buffer_registry_macros.svh
// Assertion macros shared by the registry RTL files.
// No dependencies.
`ifndef KEYED_TAIL_LOG_BUFFER_REGISTRY_MACROS_SVH
`define KEYED_TAIL_LOG_BUFFER_REGISTRY_MACROS_SVH
// Implication checked on every edge out of reset.
`define KTLB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define KTLB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hw/rtl/ktlb_pkg.sv
// Package for the keyed tail-log buffer registry: modes, status codes, payload types.
// No dependencies.
package ktlb_pkg;
  localparam logic [2:0] MODE_REGISTER = 3'd0;
  localparam logic [2:0] MODE_BIND     = 3'd1;
  localparam logic [2:0] MODE_PUSH     = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_DROPPED  = 3'd4;
  localparam logic [2:0] MODE_RELEASE  = 3'd5;
  localparam logic [2:0] MODE_NTH      = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [23:0] IDX_MASK = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] partition;
    logic [23:0] env_index;
    logic [31:0] environment_id;
    logic [31:0] owner_pid;
    logic [7:0]  data_byte;
    logic [2:0]  ordinal;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [31:0] dropped_count;
    logic [31:0] entry_partition;
    logic [31:0] entry_env_id;
    logic [23:0] entry_index;
    logic [31:0] entry_pid;
    logic [3:0]  used_count;
  } out_item_t;
endpackage

FILE: hw/rtl/ktlb_if.sv
// Valid/ready channel interfaces for the registry's input and result transactions.
// Depends on ktlb_pkg.
interface ktlb_in_if;
  import ktlb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ktlb_out_if;
  import ktlb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/keyed_tail_log_buffer_registry.sv
// Top level of the keyed tail-log buffer registry.
// Each transaction passes the front queue, the idle lookup capture and the execute stage.
// The sequencer (idle, exec, hold) pops a new transaction only after the result is taken.
// The front queue holds two transactions so input is taken while a result waits.
// Reset (rst_n low, synchronous) clears the slot table and queues; the byte memory is
// left undefined and no clearing pass runs.
module keyed_tail_log_buffer_registry #(
  parameter int ENTRY_COUNT  = 8,
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  ktlb_in_if.sink     in_ch,
  ktlb_out_if.source  out_ch
);
  import ktlb_pkg::*;

  logic     q_valid, q_pop;
  in_item_t q_item;

  ktlb_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.item),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  ktlb_back #(.ENTRY_COUNT(ENTRY_COUNT), .BUFFER_BYTES(BUFFER_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.item)
  );
endmodule

FILE: hw/rtl/ktlb_front.sv
// Front end: accepts input transactions into a two-entry queue for the back end.
// Depends on ktlb_pkg.
module ktlb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ktlb_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_pop,
  output ktlb_pkg::in_item_t  q_item
);
  import ktlb_pkg::*;

  in_item_t    mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];

  // Store payload on push
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `include "keyed_tail_log_buffer_registry_macros.svh"
  `KTLB_ASSERT_IMP(a_no_underflow, clk, rst_n, q_pop, q_valid, "pop from empty queue")
  `KTLB_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count overflow")
  `KTLB_ASSERT_NXT(a_push_visible, clk, rst_n, push, q_valid, "pushed item not visible")
endmodule

FILE: hw/rtl/ktlb_back.sv
// Back end: slot table, per-entry ring buffers in one byte memory, result register.
// Depends on ktlb_pkg.
module ktlb_back #(
  parameter int ENTRY_COUNT  = 8,
  parameter int BUFFER_BYTES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  ktlb_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ktlb_pkg::out_item_t out_item
);
  import ktlb_pkg::*;

  localparam int SW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int PW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = $clog2(ENTRY_COUNT + 1);
  localparam int AW = SW + PW;
  localparam int MD = ENTRY_COUNT * (2 ** PW);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} st_t;

  st_t st_r;
  logic [ENTRY_COUNT-1:0] used_r;
  logic [31:0] part_r [ENTRY_COUNT];
  logic [23:0] idx_r  [ENTRY_COUNT];
  logic [31:0] env_r  [ENTRY_COUNT];
  logic [31:0] pid_r  [ENTRY_COUNT];
  logic [FW-1:0] fill_r [ENTRY_COUNT];
  logic [PW-1:0] head_r [ENTRY_COUNT];
  logic [31:0] drop_r [ENTRY_COUNT];
  logic [7:0]  mem [MD];
  logic [7:0]  rdata_r;

  in_item_t   it_r;
  logic       kfound_r, efound_r, free_ok_r, nfound_r;
  logic [SW-1:0] kslot_r, eslot_r, free_r, nslot_r;
  out_item_t  res_r;
  logic [CW-1:0] used_cnt;

  // Advance a ring position, wrapping at the buffer size
  function automatic logic [PW-1:0] next_pos(logic [PW-1:0] p);
    return (p == PW'(BUFFER_BYTES - 1)) ? '0 : p + PW'(1);
  endfunction

  // Lookup logic on queue head
  logic kf, ef, ff, nf;
  logic [SW-1:0] ks, es, fs, ns;
  logic [3:0] seen;
  always_comb begin
    kf = 1'b0; ef = 1'b0; ff = 1'b0; nf = 1'b0;
    ks = '0; es = '0; fs = '0; ns = '0; seen = '0;
    for (int s = 0; s < ENTRY_COUNT; s++) begin
      if (!kf && used_r[s] && part_r[s] == q_item.partition &&
          idx_r[s] == (q_item.env_index & IDX_MASK)) begin
        kf = 1'b1; ks = SW'(s);
      end
      if (!ef && q_item.environment_id != 32'd0 && used_r[s] &&
          part_r[s] == q_item.partition && env_r[s] == q_item.environment_id) begin
        ef = 1'b1; es = SW'(s);
      end
      if (!ff && !used_r[s]) begin
        ff = 1'b1; fs = SW'(s);
      end
      if (used_r[s]) begin
        if (!nf && seen == {1'b0, q_item.ordinal}) begin
          nf = 1'b1; ns = SW'(s);
        end
        seen = seen + 4'd1;
      end
    end
  end

  always_comb begin
    used_cnt = '0;
    for (int s = 0; s < ENTRY_COUNT; s++) used_cnt = used_cnt + CW'(used_r[s]);
  end

  // Memory address for the queue head (read of oldest byte)
  logic [SW-1:0] rd_slot;
  logic [AW-1:0] rd_addr;
  assign rd_slot = ef ? es : '0;
  assign rd_addr = AW'({rd_slot, head_r[rd_slot]});

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_HOLD);
  assign out_item  = res_r;

  // Read oldest byte
  always_ff @(posedge clk) begin
    if (q_pop) rdata_r <= mem[rd_addr];
  end

  // Execute stage: write position and byte write for push
  logic [PW-1:0] wpos;
  logic [PW:0]   wsum;
  logic [FW-1:0] kfill;
  logic [PW-1:0] khead;
  assign kfill = fill_r[kslot_r];
  assign khead = head_r[kslot_r];
  assign wsum  = {1'b0, khead} + (PW+1)'(kfill);
  assign wpos  = (wsum >= (PW+1)'(BUFFER_BYTES)) ? PW'(wsum - (PW+1)'(BUFFER_BYTES))
                                                  : PW'(wsum);

  always_ff @(posedge clk) begin
    if (st_r == S_EXEC && it_r.mode == MODE_PUSH && kfound_r) begin
      if (kfill >= FW'(BUFFER_BYTES)) mem[AW'({kslot_r, khead})] <= it_r.data_byte;
      else mem[AW'({kslot_r, wpos})] <= it_r.data_byte;
    end
  end

  // Hold state, slot table and result register
  always_ff @(posedge clk) begin
    out_item_t res_nxt;
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      for (int s = 0; s < ENTRY_COUNT; s++) begin
        part_r[s] <= '0; idx_r[s] <= '0; env_r[s] <= '0; pid_r[s] <= '0;
        fill_r[s] <= '0; head_r[s] <= '0; drop_r[s] <= '0;
      end
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r <= q_item;
            kfound_r <= kf; kslot_r <= ks;
            efound_r <= ef; eslot_r <= es;
            free_ok_r <= ff; free_r <= fs;
            nfound_r <= nf; nslot_r <= ns;
            st_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_nxt = '0;
          res_nxt.status = ST_NOTFOUND;
          res_nxt.used_count = 4'(used_cnt);
          case (it_r.mode)
            MODE_REGISTER: begin
              if (kfound_r || free_ok_r) begin
                logic [SW-1:0] t;
                t = kfound_r ? kslot_r : free_r;
                used_r[t] <= 1'b1;
                part_r[t] <= it_r.partition;
                idx_r[t]  <= it_r.env_index;
                env_r[t]  <= '0;
                pid_r[t]  <= it_r.owner_pid;
                fill_r[t] <= '0; head_r[t] <= '0; drop_r[t] <= '0;
                res_nxt.status = ST_OK;
                res_nxt.used_count = 4'(used_cnt + CW'(!kfound_r));
              end else res_nxt.status = ST_FULL;
            end
            MODE_BIND: begin
              if (kfound_r && it_r.environment_id != 32'd0) begin
                env_r[kslot_r] <= it_r.environment_id;
                res_nxt.status = ST_OK;
              end
            end
            MODE_PUSH: begin
              if (kfound_r) begin
                if (kfill >= FW'(BUFFER_BYTES)) begin
                  head_r[kslot_r] <= next_pos(khead);
                  drop_r[kslot_r] <= drop_r[kslot_r] + 32'd1;
                  res_nxt.dropped_count = drop_r[kslot_r] + 32'd1;
                end else begin
                  fill_r[kslot_r] <= kfill + FW'(1);
                  res_nxt.dropped_count = drop_r[kslot_r];
                end
                res_nxt.status = ST_OK;
              end
            end
            MODE_READ: begin
              if (efound_r) begin
                res_nxt.dropped_count = drop_r[eslot_r];
                if (fill_r[eslot_r] == '0) res_nxt.status = ST_EMPTY;
                else begin
                  res_nxt.read_byte = rdata_r;
                  head_r[eslot_r] <= next_pos(head_r[eslot_r]);
                  fill_r[eslot_r] <= fill_r[eslot_r] - FW'(1);
                  res_nxt.status = ST_OK;
                end
              end
            end
            MODE_DROPPED: begin
              if (efound_r) begin
                res_nxt.dropped_count = drop_r[eslot_r];
                res_nxt.status = ST_OK;
              end
            end
            MODE_RELEASE: begin
              if (kfound_r) begin
                used_r[kslot_r] <= 1'b0;
                fill_r[kslot_r] <= '0; head_r[kslot_r] <= '0;
                drop_r[kslot_r] <= '0; env_r[kslot_r] <= '0; pid_r[kslot_r] <= '0;
                res_nxt.status = ST_OK;
                res_nxt.used_count = 4'(used_cnt - CW'(1));
              end
            end
            MODE_NTH: begin
              if (nfound_r) begin
                res_nxt.entry_partition = part_r[nslot_r];
                res_nxt.entry_env_id    = env_r[nslot_r];
                res_nxt.entry_index     = idx_r[nslot_r];
                res_nxt.entry_pid       = pid_r[nslot_r];
                res_nxt.status = ST_OK;
              end
            end
            default: ;
          endcase
          res_r <= res_nxt;
          st_r <= S_HOLD;
        end
        S_HOLD: begin
          if (out_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `include "keyed_tail_log_buffer_registry_macros.svh"
  `KTLB_ASSERT_NXT(a_exec_to_hold, clk, rst_n, st_r == S_EXEC, st_r == S_HOLD, "exec not one cycle")
  `KTLB_ASSERT_IMP(a_used_range, clk, rst_n, 1'b1, used_cnt <= CW'(ENTRY_COUNT), "bad used count")
  `KTLB_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE, "pop while busy")
endmodule
